// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while arst_n is low
`define CPVG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset
`define CPVG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cpvg_pkg.sv
// ---------------------------------------------------------------------------
// cpvg_pkg
// Constants, register indexes and the arctangent table of the curved panel
// vertex generator.
// ---------------------------------------------------------------------------
package cpvg_pkg;

	// fixed-point format
	localparam int FRAC_BITS    = 16;
	localparam int ONE_FX       = 1 << FRAC_BITS;
	localparam int FLAT_LIMIT   = (ONE_FX + 999) / 1000;
	localparam int Q30_SHIFT    = 30 - FRAC_BITS;
	localparam int MAX_SEGMENTS = 1024;

	// configuration port
	localparam int CFG_W = 21;
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANGLE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_SEGS   = 2'd3;

	// Q30 angle and CORDIC constants
	localparam int CORDIC_STEPS = 28;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [33:0] RND_Q30     = 34'sd1 <<< (Q30_SHIFT - 1);
	localparam logic signed [34:0] ONE_Q30     = 35'sd1 <<< 30;

	localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008
	};

endpackage

// File: rtl/cpvg_cordic.sv
// ---------------------------------------------------------------------------
// cpvg_cordic
// Pipelined rotation CORDIC in Q30, one iteration per register stage.
// Carries a tag alongside the data.
// ---------------------------------------------------------------------------
module cpvg_cordic #(
	parameter int TAG_W = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [32:0]      z_in,
	input  logic [TAG_W-1:0]        tag_in,
	output logic signed [33:0]      x_out,
	output logic signed [33:0]      y_out,
	output logic [TAG_W-1:0]        tag_out
);

	localparam int N = cpvg_pkg::CORDIC_STEPS;

	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [32:0] z_s [0:N];
	logic [TAG_W-1:0]   tag_s [0:N];

	// iteration zero starts from the gain-corrected unit vector
	assign x_s[0]   = cpvg_pkg::GAIN_Q30;
	assign y_s[0]   = '0;
	assign z_s[0]   = z_in;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [32:0] at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed({1'b0, cpvg_pkg::ATAN_Q30[i]});

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign x_out   = x_s[N];
	assign y_out   = y_s[N];
	assign tag_out = tag_s[N];

endmodule

// File: rtl/curved_panel_vertex_generator.sv
// ---------------------------------------------------------------------------
// curved_panel_vertex_generator
// Vertex, normal and texture coordinate of one column of a panel bent
// along a circular arc, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   signals                         transaction
//  input     in_valid/in_ready, column       one column number
//  output    out_valid/out_ready, 9 fields   one vertex record
//  config    cfg_wen, cfg_index, cfg_wdata   one register write, no wait
//
//  One column is taken every cycle while the output register holds no untaken result.
//  Most depth is in the two restoring dividers (22 stages each, one quotient
//  bit per stage, the second's first stage checks overflow) and the 28-stage CORDIC.
//  The whole pipe advances together; it stalls only while the output
//  register holds an untaken result. Reset clears all valid bits and loads
//  the register defaults.
// ---------------------------------------------------------------------------
module curved_panel_vertex_generator #(
	parameter int MAX_SEGMENTS = cpvg_pkg::MAX_SEGMENTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [cpvg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cpvg_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [10:0]                  column,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [20:0]           pos_x,
	output logic [20:0]                  pos_z,
	output logic [19:0]                  half_y,
	output logic signed [17:0]           normal_x,
	output logic signed [17:0]           normal_z,
	output logic [16:0]                  tex_u,
	output logic [10:0]                  top_vertex,
	output logic [11:0]                  bottom_vertex,
	output logic                         starts_quad
);

	localparam int DIV1_STEPS = 22;
	localparam int U_BITS     = 17;
	localparam int DIV2_STEPS = 22;
	localparam int Q2_BITS    = DIV2_STEPS - 1;
	localparam int NSTG = 1 + DIV1_STEPS + 1 + cpvg_pkg::CORDIC_STEPS + 3 + DIV2_STEPS;
	localparam logic [20:0] PX_MAX = 21'h0FFFFF;
	localparam logic [20:0] PX_MIN = 21'h100000;
	localparam logic [20:0] PZ_MAX = 21'h1FFFFF;

	typedef struct packed {
		logic [10:0] col;
		logic [16:0] u;
		logic [22:0] cen;
	} side_t;

	typedef struct packed {
		logic [17:0] nx;
		logic [17:0] nz;
		logic        neg_x;
		logic        neg_z;
	} post_t;

	// clamp a rounded Q16 normal component to [-1, 1]
	function automatic logic [17:0] clamp_unit(input logic signed [33:0] v);
		if (v > cpvg_pkg::ONE_FX)
			return 18'(cpvg_pkg::ONE_FX);
		if (v < -cpvg_pkg::ONE_FX)
			return 18'(-cpvg_pkg::ONE_FX);
		return v[17:0];
	endfunction

	// -----------------------------------------------------------------
	// configuration registers
	// -----------------------------------------------------------------
	logic [20:0] width_q;
	logic [20:0] height_q;
	logic [18:0] arc_q;
	logic [10:0] seg_q;
	logic [10:0] seg_wr;

	always_comb begin
		seg_wr = cfg_wdata[10:0];
		if (seg_wr == '0)
			seg_wr = 11'd1;
		else if ({5'd0, seg_wr} > 16'(MAX_SEGMENTS))
			seg_wr = 11'(MAX_SEGMENTS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 21'(cpvg_pkg::ONE_FX);
			height_q <= 21'(cpvg_pkg::ONE_FX);
			arc_q    <= '0;
			seg_q    <= 11'd1;
		end else if (cfg_wen) begin
			case (cfg_index)
				cpvg_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
				cpvg_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				cpvg_pkg::REG_ANGLE:  arc_q    <= cfg_wdata[18:0];
				cpvg_pkg::REG_SEGS:   seg_q    <= seg_wr;
				default: ;
			endcase
		end
	end

	logic        flat;
	logic [20:0] span;
	logic [11:0] div1_d;

	assign flat   = arc_q < 19'(cpvg_pkg::FLAT_LIMIT);
	assign span   = flat ? width_q : {2'd0, arc_q};
	assign div1_d = {seg_q, 1'b0};

	// -----------------------------------------------------------------
	// handshake: the pipe moves as one while the output can take data
	// -----------------------------------------------------------------
	logic            adv;
	logic [NSTG-1:0] vld_q;
	logic            out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NSTG-2:0], in_valid};
			out_valid_q <= vld_q[NSTG-1];
		end
	end

	// -----------------------------------------------------------------
	// stage 1: clamp column, build dividends
	// -----------------------------------------------------------------
	logic [10:0] col_c;
	logic [12:0] mul_a;
	logic [33:0] k_c;
	logic [27:0] ku_c;

	assign col_c = (column > seg_q) ? seg_q : column;
	assign mul_a = {1'b0, col_c, 1'b0} + {2'd0, seg_q};
	assign k_c   = {21'd0, mul_a} * {13'd0, span} + {23'd0, seg_q};
	assign ku_c  = {col_c, 17'd0} + {17'd0, seg_q};

	logic [33:0] krem_s [0:DIV1_STEPS];
	logic [21:0] kquo_s [0:DIV1_STEPS];
	logic [27:0] urem_s [0:DIV1_STEPS];
	logic [16:0] uquo_s [0:DIV1_STEPS];
	side_t       side_s [0:DIV1_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			krem_s[0] <= k_c;
			kquo_s[0] <= '0;
			urem_s[0] <= ku_c;
			uquo_s[0] <= '0;
			side_s[0] <= '{col: col_c, u: '0, cen: '0};
		end
	end

	// -----------------------------------------------------------------
	// divider 1: centered position / angle and texture u, by 2*segments
	// -----------------------------------------------------------------
	for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
		localparam int B = DIV1_STEPS - 1 - j;
		logic [33:0] kd;
		logic [27:0] ud;

		assign kd = 34'(div1_d) << B;
		assign ud = 28'(div1_d) << (B % U_BITS);

		always_ff @(posedge clk) begin
			if (adv) begin
				if (krem_s[j] >= kd) begin
					krem_s[j+1] <= krem_s[j] - kd;
					kquo_s[j+1] <= kquo_s[j] | (22'd1 << B);
				end else begin
					krem_s[j+1] <= krem_s[j];
					kquo_s[j+1] <= kquo_s[j];
				end
				if (B < U_BITS && urem_s[j] >= ud) begin
					urem_s[j+1] <= urem_s[j] - ud;
					uquo_s[j+1] <= uquo_s[j] | (17'd1 << (B % U_BITS));
				end else begin
					urem_s[j+1] <= urem_s[j];
					uquo_s[j+1] <= uquo_s[j];
				end
				side_s[j+1] <= side_s[j];
			end
		end
	end

	// -----------------------------------------------------------------
	// stage A: recenter, scale to Q30 and fold into +-pi/2
	// -----------------------------------------------------------------
	logic signed [22:0] cen_c;
	logic signed [33:0] ang_c;
	logic signed [33:0] fold_c;
	logic               flip_c;
	side_t              side_c;

	always_comb begin
		cen_c  = $signed({1'b0, kquo_s[DIV1_STEPS]}) - $signed({2'd0, span});
		ang_c  = $signed({cen_c[19:0], 14'd0}) <<< (cpvg_pkg::Q30_SHIFT - 14);
		flip_c = 1'b1;
		if (ang_c > cpvg_pkg::HALF_PI_Q30)
			fold_c = ang_c - cpvg_pkg::PI_Q30;
		else if (ang_c < -cpvg_pkg::HALF_PI_Q30)
			fold_c = ang_c + cpvg_pkg::PI_Q30;
		else begin
			fold_c = ang_c;
			flip_c = 1'b0;
		end
		side_c     = side_s[DIV1_STEPS];
		side_c.u   = uquo_s[DIV1_STEPS];
		side_c.cen = cen_c;
	end

	logic signed [32:0] z_sa;
	logic               flip_sa;
	side_t              side_sa;

	always_ff @(posedge clk) begin
		if (adv) begin
			z_sa    <= fold_c[32:0];
			flip_sa <= flip_c;
			side_sa <= side_c;
		end
	end

	// -----------------------------------------------------------------
	// CORDIC
	// -----------------------------------------------------------------
	logic signed [33:0] cx;
	logic signed [33:0] cy;
	logic               flip_co;
	side_t              side_co;

	cpvg_cordic #(
		.TAG_W ($bits(side_t) + 1)
	) u_cordic (
		.clk     (clk),
		.en      (adv),
		.z_in    (z_sa),
		.tag_in  ({flip_sa, side_sa}),
		.x_out   (cx),
		.y_out   (cy),
		.tag_out ({flip_co, side_co})
	);

	// -----------------------------------------------------------------
	// stage B: unfold, normals, magnitudes for the position divides
	// -----------------------------------------------------------------
	logic signed [33:0] s30;
	logic signed [33:0] c30;
	logic signed [33:0] s_rnd;
	logic signed [33:0] c_rnd;
	logic signed [33:0] s_abs;
	logic signed [34:0] dz;
	logic signed [34:0] dz_abs;

	always_comb begin
		s30    = flip_co ? -cy : cy;
		c30    = flip_co ? -cx : cx;
		s_rnd  = (s30 + cpvg_pkg::RND_Q30) >>> cpvg_pkg::Q30_SHIFT;
		c_rnd  = (c30 + cpvg_pkg::RND_Q30) >>> cpvg_pkg::Q30_SHIFT;
		s_abs  = s30[33] ? -s30 : s30;
		dz     = cpvg_pkg::ONE_Q30 - $signed({c30[33], c30});
		dz_abs = dz[34] ? -dz : dz;
	end

	logic [31:0] magx_sb;
	logic [31:0] magz_sb;
	post_t       post_sb;
	side_t       side_sb;

	always_ff @(posedge clk) begin
		if (adv) begin
			magx_sb       <= s_abs[31:0];
			magz_sb       <= dz_abs[31:0];
			post_sb.nx    <= clamp_unit(-s_rnd);
			post_sb.nz    <= clamp_unit(c_rnd);
			post_sb.neg_x <= s30[33];
			post_sb.neg_z <= dz[34];
			side_sb       <= side_co;
		end
	end

	// -----------------------------------------------------------------
	// stage C: width times sine and times (1 - cosine)
	// -----------------------------------------------------------------
	logic [52:0] prodx_sc;
	logic [52:0] prodz_sc;
	post_t       post_sc;
	side_t       side_sc;

	always_ff @(posedge clk) begin
		if (adv) begin
			prodx_sc <= {32'd0, width_q} * {21'd0, magx_sb};
			prodz_sc <= {32'd0, width_q} * {21'd0, magz_sb};
			post_sc  <= post_sb;
			side_sc  <= side_sb;
		end
	end

	// -----------------------------------------------------------------
	// stage D: add half divisor for rounding, drop the Q30/Q16 gap
	// -----------------------------------------------------------------
	logic [53:0] rnd_add;
	logic [53:0] sumx_c;
	logic [53:0] sumz_c;

	assign rnd_add = {22'd0, arc_q, 13'd0};
	assign sumx_c  = {1'b0, prodx_sc} + rnd_add;
	assign sumz_c  = {1'b0, prodz_sc} + rnd_add;

	logic [39:0] xrem_s [0:DIV2_STEPS];
	logic [20:0] xquo_s [0:DIV2_STEPS];
	logic        xsat_s [0:DIV2_STEPS];
	logic [39:0] zrem_s [0:DIV2_STEPS];
	logic [20:0] zquo_s [0:DIV2_STEPS];
	logic        zsat_s [0:DIV2_STEPS];
	post_t       post_s [0:DIV2_STEPS];
	side_t       side2_s [0:DIV2_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			xrem_s[0]  <= sumx_c[53:14];
			zrem_s[0]  <= sumz_c[53:14];
			xquo_s[0]  <= '0;
			zquo_s[0]  <= '0;
			xsat_s[0]  <= 1'b0;
			zsat_s[0]  <= 1'b0;
			post_s[0]  <= post_sc;
			side2_s[0] <= side_sc;
		end
	end

	// -----------------------------------------------------------------
	// divider 2: positions by arc angle; first step flags overflow
	// -----------------------------------------------------------------
	for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
		localparam int B = Q2_BITS - j;
		logic [39:0] ad;

		assign ad = 40'(arc_q) << B;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (j == 0) begin
					xrem_s[j+1] <= xrem_s[j];
					xquo_s[j+1] <= xquo_s[j];
					xsat_s[j+1] <= xrem_s[j] >= ad;
					zrem_s[j+1] <= zrem_s[j];
					zquo_s[j+1] <= zquo_s[j];
					zsat_s[j+1] <= zrem_s[j] >= ad;
				end else begin
					xsat_s[j+1] <= xsat_s[j];
					zsat_s[j+1] <= zsat_s[j];
					if (!xsat_s[j] && xrem_s[j] >= ad) begin
						xrem_s[j+1] <= xrem_s[j] - ad;
						xquo_s[j+1] <= xquo_s[j] | (21'd1 << (B % Q2_BITS));
					end else begin
						xrem_s[j+1] <= xrem_s[j];
						xquo_s[j+1] <= xquo_s[j];
					end
					if (!zsat_s[j] && zrem_s[j] >= ad) begin
						zrem_s[j+1] <= zrem_s[j] - ad;
						zquo_s[j+1] <= zquo_s[j] | (21'd1 << (B % Q2_BITS));
					end else begin
						zrem_s[j+1] <= zrem_s[j];
						zquo_s[j+1] <= zquo_s[j];
					end
				end
				post_s[j+1]  <= post_s[j];
				side2_s[j+1] <= side2_s[j];
			end
		end
	end

	// -----------------------------------------------------------------
	// final stage: signs, saturation, flat panel, vertex numbers
	// -----------------------------------------------------------------
	post_t              pf;
	side_t              sf;
	logic [20:0]        qx;
	logic [20:0]        qz;
	logic signed [22:0] cen_f;
	logic [20:0]        px_c;
	logic [20:0]        pz_c;
	logic [17:0]        nx_c;
	logic [17:0]        nz_c;

	always_comb begin
		pf    = post_s[DIV2_STEPS];
		sf    = side2_s[DIV2_STEPS];
		qx    = xquo_s[DIV2_STEPS];
		qz    = zquo_s[DIV2_STEPS];
		cen_f = $signed(sf.cen);
		if (flat) begin
			if (cen_f > $signed({2'd0, PX_MAX}))
				px_c = PX_MAX;
			else if (cen_f < -$signed({2'd0, PX_MIN}))
				px_c = PX_MIN;
			else
				px_c = sf.cen[20:0];
			pz_c = '0;
			nx_c = '0;
			nz_c = 18'(cpvg_pkg::ONE_FX);
		end else begin
			if (!pf.neg_x)
				px_c = (xsat_s[DIV2_STEPS] || qx >= PX_MIN) ? PX_MAX : qx;
			else
				px_c = (xsat_s[DIV2_STEPS] || qx > PX_MIN) ? PX_MIN : (~qx + 21'd1);
			if (pf.neg_z)
				pz_c = '0;
			else
				pz_c = zsat_s[DIV2_STEPS] ? PZ_MAX : qz;
			nx_c = pf.nx;
			nz_c = pf.nz;
		end
	end

	logic [20:0] pos_x_q;
	logic [20:0] pos_z_q;
	logic [17:0] normal_x_q;
	logic [17:0] normal_z_q;
	logic [16:0] tex_u_q;
	logic [10:0] top_q;
	logic [11:0] bottom_q;
	logic        quad_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x_q    <= px_c;
			pos_z_q    <= pz_c;
			normal_x_q <= nx_c;
			normal_z_q <= nz_c;
			tex_u_q    <= sf.u;
			top_q      <= sf.col;
			bottom_q   <= {1'b0, seg_q} + 12'd1 + {1'b0, sf.col};
			quad_q     <= sf.col < seg_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pos_x         = $signed(pos_x_q);
	assign pos_z         = pos_z_q;
	assign half_y        = height_q[20:1];
	assign normal_x      = $signed(normal_x_q);
	assign normal_z      = $signed(normal_z_q);
	assign tex_u         = tex_u_q;
	assign top_vertex    = top_q;
	assign bottom_vertex = bottom_q;
	assign starts_quad   = quad_q;

endmodule

// File: rtl/cpvg_checker.sv
// ---------------------------------------------------------------------------
// cpvg_checker
// Port-level checks of the curved panel vertex generator, bound to the
// top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpvg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_wen,
	input logic [cpvg_pkg::IDX_W-1:0]   cfg_index,
	input logic [cpvg_pkg::CFG_W-1:0]   cfg_wdata,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [10:0]                  column,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [20:0]           pos_x,
	input logic [20:0]                  pos_z,
	input logic [19:0]                  half_y,
	input logic signed [17:0]           normal_x,
	input logic signed [17:0]           normal_z,
	input logic [16:0]                  tex_u,
	input logic [10:0]                  top_vertex,
	input logic [11:0]                  bottom_vertex,
	input logic                         starts_quad
);

	// a held result keeps its position and texture coordinate
	`CPVG_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_z) && $stable(tex_u), "result changed while stalled")

	// input side blocks only behind an untaken result
	`CPVG_ASSERT(a_ready, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

	// a quad starts exactly when the column lies below the segment count
	`CPVG_ASSERT(a_quad, out_valid |-> starts_quad == (bottom_vertex > 2 * top_vertex + 1), "quad flag disagrees with vertex numbers")

	// normal and texture coordinate stay within unit range
	`CPVG_ASSERT(a_range, out_valid |-> normal_x <= 65536 && normal_x >= -65536 && normal_z <= 65536 && normal_z >= -65536 && tex_u <= 65536, "normal or u out of range")

	// nothing leaves while in reset
	`CPVG_ASSERT_ALWAYS(a_rst, !arst_n |=> !out_valid, "output valid during reset")

endmodule

bind curved_panel_vertex_generator cpvg_checker u_cpvg_checker (.*);

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the curved panel vertex generator: random and
// directed columns over several panel shapes, each result compared with a
// fixed-point model of the arc vertex.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic signed [20:0] px;
		logic [20:0]        pz;
		logic [19:0]        hy;
		logic signed [17:0] nx;
		logic signed [17:0] nz;
		logic [16:0]        u;
		logic [10:0]        top;
		logic [11:0]        bot;
		logic               quad;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [cpvg_pkg::IDX_W-1:0] cfg_index = '0;
	logic [cpvg_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [10:0] column = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [20:0] pos_x;
	logic [20:0] pos_z;
	logic [19:0] half_y;
	logic signed [17:0] normal_x, normal_z;
	logic [16:0] tex_u;
	logic [10:0] top_vertex;
	logic [11:0] bottom_vertex;
	logic starts_quad;

	curved_panel_vertex_generator dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// panel shape as the block holds it
	longint shape_w = 65536, shape_h = 65536, shape_ang = 0, shape_segs = 1;

	logic [10:0] pending_cols[$];
	vertex_t     expected_vertices[$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_flat = 0, n_bent = 0;
	longint      cycle = 0;
	bit          hold_input = 0;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_div(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	// round(-v/2 + col*v/seg), ties up
	function automatic longint centered_val(longint col, longint seg, longint v);
		return (2 * col * v + seg * v + seg) / (2 * seg) - v;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic vertex_t vertex_of_column(logic [10:0] col_in);
		vertex_t r;
		longint col, seg, px, pz, nx, nz, a, xx, yy, zz, dx, dy, den, rnd;
		bit flip;
		seg = shape_segs;
		col = col_in;
		if (col > seg)
			col = seg;
		if (shape_ang < cpvg_pkg::FLAT_LIMIT) begin
			px = centered_val(col, seg, shape_w);
			pz = 0;
			nx = 0;
			nz = cpvg_pkg::ONE_FX;
		end else begin
			a = centered_val(col, seg, shape_ang);
			// rotation CORDIC with fold beyond a quarter turn
			zz = a <<< cpvg_pkg::Q30_SHIFT;
			xx = cpvg_pkg::GAIN_Q30;
			yy = 0;
			flip = 0;
			if (zz > cpvg_pkg::HALF_PI_Q30) begin
				zz -= cpvg_pkg::PI_Q30;
				flip = 1;
			end else if (zz < -cpvg_pkg::HALF_PI_Q30) begin
				zz += cpvg_pkg::PI_Q30;
				flip = 1;
			end
			for (int i = 0; i < cpvg_pkg::CORDIC_STEPS; i++) begin
				dx = floor_shr(yy, i);
				dy = floor_shr(xx, i);
				if (zz >= 0) begin
					xx -= dx; yy += dy; zz -= longint'(cpvg_pkg::ATAN_Q30[i]);
				end else begin
					xx += dx; yy -= dy; zz += longint'(cpvg_pkg::ATAN_Q30[i]);
				end
			end
			if (flip) begin
				xx = -xx;
				yy = -yy;
			end
			den = shape_ang <<< cpvg_pkg::Q30_SHIFT;
			rnd = 64'sd1 <<< (cpvg_pkg::Q30_SHIFT - 1);
			px = round_div(shape_w * yy, den);
			pz = round_div(shape_w * ((64'sd1 <<< 30) - xx), den);
			nx = clip(-floor_shr(yy + rnd, cpvg_pkg::Q30_SHIFT),
				-cpvg_pkg::ONE_FX, cpvg_pkg::ONE_FX);
			nz = clip(floor_shr(xx + rnd, cpvg_pkg::Q30_SHIFT),
				-cpvg_pkg::ONE_FX, cpvg_pkg::ONE_FX);
		end
		px = clip(px, -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1);
		pz = clip(pz, 0, (64'sd1 <<< 21) - 1);
		r.px = px[20:0];
		r.pz = pz[20:0];
		r.hy = 20'(shape_h >> 1);
		r.nx = nx[17:0];
		r.nz = nz[17:0];
		r.u = 17'((2 * col * cpvg_pkg::ONE_FX + seg) / (2 * seg));
		r.top = col[10:0];
		r.bot = 12'(seg + 1 + col);
		r.quad = col < seg;
		return r;
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 99) < 50)
			return 0;
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// cycle counter and run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("Timeout at cycle %0d", cycle);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// driver: one column per transaction, random gaps except in bursty phases
	int in_gap = 0;
	bit bursty = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_vertices.push_back(vertex_of_column(column));
				if (shape_ang < cpvg_pkg::FLAT_LIMIT) n_flat++; else n_bent++;
			end
			if (in_valid && !in_ready) begin
				// hold payload
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_cols.size() > 0 && !hold_input) begin
				in_valid <= 1'b1;
				column <= pending_cols.pop_front();
				in_gap <= bursty ? 0 : short_or_long_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: stall at random outside bursty phases, compare each vertex transaction
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{pos_x, pos_z, half_y, normal_x, normal_z, tex_u,
					top_vertex, bottom_vertex, starts_quad};
				if (expected_vertices.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("Unexpected vertex %p", got);
				end else begin
					want = expected_vertices.pop_front();
					n_checked++;
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("Mismatch: expected %p, got %p", want, got);
					end
				end
			end
			out_ready <= bursty ? 1'b1 : (short_or_long_gap() == 0);
		end
	end

	task automatic write_reg(logic [cpvg_pkg::IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= cpvg_pkg::CFG_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			cpvg_pkg::REG_WIDTH:  shape_w = val & 64'h1FFFFF;
			cpvg_pkg::REG_HEIGHT: shape_h = val & 64'h1FFFFF;
			cpvg_pkg::REG_ANGLE:  shape_ang = val & 64'h7FFFF;
			default: begin
				shape_segs = val & 64'h7FF;
				if (shape_segs == 0) shape_segs = 1;
				if (shape_segs > cpvg_pkg::MAX_SEGMENTS) shape_segs = cpvg_pkg::MAX_SEGMENTS;
			end
		endcase
	endtask

	// wait for the pipe to empty, then let stragglers drain
	task automatic drain();
		while (pending_cols.size() > 0 || in_valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_shape(longint w, longint h, longint ang, longint segs);
		write_reg(cpvg_pkg::REG_WIDTH, w);
		write_reg(cpvg_pkg::REG_HEIGHT, h);
		write_reg(cpvg_pkg::REG_ANGLE, ang);
		write_reg(cpvg_pkg::REG_SEGS, segs);
	endtask

	function automatic logic [10:0] rand_column();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 11'($urandom);
		if (k == 1) return 11'(shape_segs + $urandom_range(0, 3));
		return 11'($urandom_range(0, shape_segs));
	endfunction

	initial begin
		longint segs, ang;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// reset defaults first
		pending_cols = '{0, 1, 2, 2047};
		drain();

		// directed: flat, wide, narrow, tie and saturation shapes
		set_shape(1048576, 2097151, 0, 0);
		pending_cols = '{0, 1, 1024};
		drain();
		set_shape(65536, 131072, 65, 4);
		pending_cols = '{0, 2, 4, 5};
		drain();
		set_shape(1048576, 0, 411775, 2047);
		pending_cols = '{0, 512, 1023, 1024, 2047};
		drain();
		set_shape(131072, 65537, 66, 3);
		pending_cols = '{0, 1, 2, 3};
		drain();
		set_shape(2097151, 1048576, 524287, 7);
		pending_cols = '{0, 1, 3, 6, 7};
		drain();
		set_shape(0, 65536, 205887, 1);
		pending_cols = '{0, 1};
		drain();

		// random phases with new shapes between them
		for (int ph = 0; ph < 16; ph++) begin
			segs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(1, 64);
			ang = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
				: $urandom_range(66, 411775);
			set_shape($urandom_range(0, 1048576), $urandom_range(0, 2097151), ang, segs);
			bursty = (ph % 4 == 3);
			for (int i = 0; i < 100; i++)
				pending_cols.push_back(rand_column());
			// at one point the sender holds off until the pipe is empty
			if (ph == 5) begin
				while (pending_cols.size() > 50) @(posedge clk);
				hold_input = 1;
				while (in_valid || expected_vertices.size() > 0) @(posedge clk);
				hold_input = 0;
			end
			drain();
		end

		$display("Checked %0d vertices: %0d flat, %0d on an arc, over 23 panel shapes",
			n_checked, n_flat, n_bent);
		if (n_errors == 0 && expected_vertices.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d vertices missing", n_errors,
				expected_vertices.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/cpvg_pkg.sv
rtl/cpvg_cordic.sv
rtl/curved_panel_vertex_generator.sv
rtl/cpvg_checker.sv
tb/tb.sv
